FILE: hdl/ubds_pkg.sv
// ----------------------------------------------------------------------------
// UART baud divisor select package
// Shared widths, mode codes and the request record passed through the queue.
// ----------------------------------------------------------------------------
package ubds_pkg;

    localparam int BAUD_W = 21;
    localparam int MODE_W = 2;
    localparam int DIV_W  = 16;

    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd1;

    // Request record handed from the front end to the divider back end
    typedef struct packed {
        logic [BAUD_W-1:0] baud;
        logic [MODE_W-1:0] mode;
    } ubds_req_t;

endpackage

FILE: hdl/uart_baud_divisor_select_core.sv
// Each request runs four divisions on the shared divider, then the pick step.
// The divider handles one request at a time; later requests wait in the queue.
// A two-entry request queue takes new requests while the divider works.
// busy is high only when the queue is full; done pulses for one cycle.
// rst_n clears the queue and the sequencer asynchronously.
// ----------------------------------------------------------------------------
// UART baud divisor select core
// Top level: request queue front end and sequential divider back end.
// ----------------------------------------------------------------------------
module uart_baud_divisor_select_core
    import ubds_pkg::*;
#(
    parameter int CLOCK_HZ = 16000000
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [BAUD_W-1:0] baud_rate,
    input  logic [MODE_W-1:0] speed_mode,
    output logic              done,
    output logic [DIV_W-1:0]  divisor,
    output logic              double_speed
);

    logic      q_valid, q_pop;
    ubds_req_t q_data;

    ubds_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .baud_rate(baud_rate),
        .speed_mode(speed_mode), .busy(busy), .q_valid(q_valid),
        .q_data(q_data), .q_pop(q_pop)
    );

    ubds_back #(.CLOCK_HZ(CLOCK_HZ)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
        .q_pop(q_pop), .done(done), .divisor(divisor),
        .double_speed(double_speed)
    );

endmodule

FILE: hdl/ubds_front.sv
// ----------------------------------------------------------------------------
// UART baud divisor select front end
// Accepts requests, clamps zero baud to one, and feeds a two-entry queue.
// ----------------------------------------------------------------------------
module ubds_front
    import ubds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [BAUD_W-1:0] baud_rate,
    input  logic [MODE_W-1:0] speed_mode,
    output logic              busy,
    output logic              q_valid,
    output ubds_req_t         q_data,
    input  logic              q_pop
);

    ubds_req_t   mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    ubds_req_t   req;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        req.baud = (baud_rate == '0) ? BAUD_W'(1) : baud_rate;
        req.mode = speed_mode;
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: hdl/ubds_back.sv
// ----------------------------------------------------------------------------
// UART baud divisor select back end
// Runs four restoring divisions on one shared unit and picks the divisor.
// ----------------------------------------------------------------------------
module ubds_back
    import ubds_pkg::*;
#(
    parameter int CLOCK_HZ = 16000000
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  ubds_req_t        q_data,
    output logic             q_pop,
    output logic             done,
    output logic [DIV_W-1:0] divisor,
    output logic             double_speed
);

    localparam int NW = 32;
    localparam int DW = 40;
    localparam int CW = 6;

    typedef enum logic [2:0] {S_IDLE, S_D16, S_D8, S_R16, S_R8, S_PICK} state_t;

    state_t           state_reg;
    logic [NW-1:0]    num_reg;
    logic [DW-1:0]    den_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic [BAUD_W-1:0] baud_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [DIV_W-1:0] d16_reg, d8_reg;
    logic [NW-1:0]    r16_reg;
    logic [DIV_W-1:0] divisor_reg;
    logic             dbl_reg, done_reg;

    logic [DW-1:0]    rem_sh;
    logic             fits;
    logic [DIV_W-1:0] qdiv;
    logic [NW-1:0]    e8, e16;

    assign rem_sh = {rem_reg[DW-2:0], num_reg[NW-1]};
    assign fits   = (rem_sh >= den_reg);
    assign qdiv   = quo_reg[DIV_W-1:0] - DIV_W'(1);
    assign q_pop  = (state_reg == S_IDLE) && q_valid;

    assign done         = done_reg;
    assign divisor      = divisor_reg;
    assign double_speed = dbl_reg;

    always_comb
    begin
        e16 = ({11'd0, baud_reg} > r16_reg) ? {11'd0, baud_reg} - r16_reg
                                             : r16_reg - {11'd0, baud_reg};
        e8  = ({11'd0, baud_reg} > quo_reg) ? {11'd0, baud_reg} - quo_reg
                                             : quo_reg - {11'd0, baud_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_PICK);
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        baud_reg  <= q_data.baud;
                        mode_reg  <= q_data.mode;
                        num_reg   <= NW'(CLOCK_HZ) + {8'd0, q_data.baud, 3'd0};
                        den_reg   <= {15'd0, q_data.baud, 4'd0};
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_D16;
                    end
                end
                S_PICK:
                begin
                    // quo_reg holds r8 here
                    if (mode_reg == MODE_NORMAL)
                        dbl_reg <= 1'b0;
                    else if (mode_reg == MODE_DOUBLE)
                        dbl_reg <= 1'b1;
                    else
                        dbl_reg <= (e8 < e16);
                    if (mode_reg == MODE_NORMAL)
                        divisor_reg <= d16_reg;
                    else if (mode_reg == MODE_DOUBLE)
                        divisor_reg <= d8_reg;
                    else
                        divisor_reg <= (e8 < e16) ? d8_reg : d16_reg;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    if (cnt_reg == CW'(NW))
                    begin
                        rem_reg <= '0;
                        cnt_reg <= '0;
                        case (state_reg)
                            S_D16:
                            begin
                                d16_reg   <= qdiv;
                                quo_reg   <= '0;
                                num_reg   <= NW'(CLOCK_HZ) + {9'd0, baud_reg, 2'd0};
                                den_reg   <= {16'd0, baud_reg, 3'd0};
                                state_reg <= S_D8;
                            end
                            S_D8:
                            begin
                                d8_reg    <= qdiv;
                                quo_reg   <= '0;
                                num_reg   <= NW'(CLOCK_HZ);
                                den_reg   <= {20'd0, {1'b0, d16_reg} + 17'd1, 3'd0} << 1;
                                state_reg <= S_R16;
                            end
                            S_R16:
                            begin
                                r16_reg   <= quo_reg;
                                quo_reg   <= '0;
                                num_reg   <= NW'(CLOCK_HZ);
                                den_reg   <= {20'd0, {1'b0, d8_reg} + 17'd1, 3'd0};
                                state_reg <= S_R8;
                            end
                            default:
                            begin
                                // hold the quotient for the pick
                                state_reg <= S_PICK;
                            end
                        endcase
                    end
                    else
                    begin
                        // one quotient bit a cycle
                        rem_reg <= fits ? rem_sh - den_reg : rem_sh;
                        quo_reg <= {quo_reg[NW-2:0], fits};
                        num_reg <= {num_reg[NW-2:0], 1'b0};
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
            endcase
        end
    end

endmodule

FILE: hdl/ubds_checker.sv
// ----------------------------------------------------------------------------
// UART baud divisor select checker
// Port-level checks on request and result timing.
// ----------------------------------------------------------------------------
module ubds_checker
    import ubds_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             busy,
    input logic             done,
    input logic [DIV_W-1:0] divisor,
    input logic             double_speed
);

    // results never come back to back: each needs four divisions first
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done on consecutive cycles");

    // no result right after reset without a request
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !done) else $error("done right after reset");

    // a full queue cannot clear without the divider finishing soon
    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy && !done |=> busy || $past(done) || done)
        else $error("busy dropped without progress");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({divisor, double_speed}))
        else $error("unknown result");

endmodule

bind uart_baud_divisor_select_core ubds_checker u_checker (
    .clk(clk), .rst_n(rst_n), .busy(busy), .done(done),
    .divisor(divisor), .double_speed(double_speed)
);
